@@ rtl/kmp_pkg.sv @@
`timescale 1ns / 1ps
// kmp_pkg: shared types and codes for the streaming KMP matcher.
// No dependencies; used by kmp_stream_matcher.

package kmp_pkg;

   // Width of one pattern or text symbol
   localparam int SYM_W = 8;
   // Width of the reported start position
   localparam int POS_W = 32;

   // Request codes carried in req_type
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_TEXT   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // Input word
   typedef struct packed {
      logic [1:0]       req_type;
      logic [SYM_W-1:0] symbol;
      logic             last;
   } kmp_req_type;

   // Result word
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } kmp_rsp_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } kmp_state_type;

endpackage

@@ rtl/kmp_stream_matcher.sv @@
`timescale 1ns / 1ps
// kmp_stream_matcher: single-pattern KMP matcher over a byte stream; uses kmp_pkg, kmp_ram.
// Timing: a walking byte is accepted, then walks in ST_WALK with one RAM read per step (an
// empty-pattern text byte walks one step with no read); a held result word stalls the last.
// No new word is accepted until the walk ends; clear, ignored, first-append and post-match
// words complete on acceptance without a walk.
// Reset: synchronous, empties the pattern and matcher; the RAM needs no clearing.

module kmp_stream_matcher #(
   parameter int MAX_PATTERN     = 256,
   parameter int TEXT_INDEX_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kmp_pkg::kmp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kmp_pkg::kmp_rsp_type rsp_data
);

   localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int TIB    = TEXT_INDEX_BITS;
   localparam int CALC_W = (TIB > kmp_pkg::POS_W) ? TIB : kmp_pkg::POS_W;
   localparam int RAM_W  = kmp_pkg::SYM_W + IDX_W;

   // Control state
   kmp_pkg::kmp_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       match_ff, match_in;
   logic [TIB-1:0]         tindex_ff, tindex_in;
   logic                   reported_ff, reported_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Per-word working registers
   logic [IDX_W-1:0]         fprev_ff, fprev_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [kmp_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic                     last_ff, last_in;
   logic                     is_text_ff, is_text_in;
   logic                     empty_ff, empty_in;
   logic [TIB-1:0]           here_ff, here_in;
   kmp_pkg::kmp_rsp_type     rsp_data_ff, rsp_data_in;

   // RAM: entry i holds {failure[i-1], pattern[i]}, so one read serves a walk step
   logic                      wr_en, rd_en;
   logic [IDX_W-1:0]          wr_addr, rd_addr;
   logic [RAM_W-1:0]          wr_data, rd_data;
   logic [kmp_pkg::SYM_W-1:0] r_sym;
   logic [IDX_W-1:0]          r_fail;

   logic             req_fire, full, start_walk;
   logic             eq, walk_done, hit, emit, stall, finish;
   logic [CNT_W-1:0] step_res, text_start;
   logic [CALC_W-1:0] pos_full;

   kmp_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_PATTERN)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign r_sym  = rd_data[kmp_pkg::SYM_W-1:0];
   assign r_fail = rd_data[kmp_pkg::SYM_W +: IDX_W];

   // Handshake
   assign req_ready = (state_ff == kmp_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Accept-side decode
   assign full       = (count_ff == CNT_W'(MAX_PATTERN));
   assign text_start = (match_ff >= count_ff) ? '0 : match_ff;
   assign start_walk = req_fire &&
      (((req_data.req_type == kmp_pkg::REQ_APPEND) && !full && (count_ff != '0)) ||
       ((req_data.req_type == kmp_pkg::REQ_TEXT) && !reported_ff));

   // Walk step: compare stored symbol, else follow the failure link
   assign eq        = (r_sym == sym_ff);
   assign walk_done = empty_ff || eq || (idx_ff == '0);
   assign step_res  = eq ? (CNT_W'(idx_ff) + CNT_W'(1)) : '0;
   assign hit       = empty_ff || (step_res == count_ff);
   assign emit      = is_text_ff && (hit || last_ff);
   assign stall     = walk_done && emit && rsp_valid_ff && !rsp_ready;
   assign finish    = walk_done && !stall;
   assign pos_full  = CALC_W'(here_ff) - CALC_W'(count_ff) + CALC_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (start_walk) begin
               state_in = kmp_pkg::ST_WALK;
            end
         end
         kmp_pkg::ST_WALK: begin
            if (finish) begin
               state_in = kmp_pkg::ST_IDLE;
            end
         end
         default: state_in = kmp_pkg::ST_IDLE;
      endcase
   end

   // Datapath, RAM control and result word
   always_comb begin
      count_in     = count_ff;
      match_in     = match_ff;
      tindex_in    = tindex_ff;
      reported_in  = reported_ff;
      fprev_in     = fprev_ff;
      idx_in       = idx_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      is_text_in   = is_text_ff;
      empty_in     = empty_ff;
      here_in      = here_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = {fprev_ff, req_data.symbol};
      rd_en        = 1'b0;
      rd_addr      = idx_ff;

      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (req_fire) begin
               sym_in     = req_data.symbol;
               last_in    = req_data.last;
               is_text_in = (req_data.req_type == kmp_pkg::REQ_TEXT);
               empty_in   = (count_ff == '0);
               here_in    = tindex_ff;
               case (req_data.req_type)
                  kmp_pkg::REQ_APPEND: begin
                     if (!full) begin
                        // new entry never lies on its own walk, so no forwarding
                        wr_en       = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                        match_in    = '0;
                        tindex_in   = '0;
                        reported_in = 1'b0;
                        if (count_ff == '0) begin
                           fprev_in = '0;
                        end else begin
                           idx_in  = fprev_ff;
                           rd_en   = 1'b1;
                           rd_addr = fprev_ff;
                        end
                     end
                  end
                  kmp_pkg::REQ_TEXT: begin
                     // index saturates at all ones
                     if (tindex_ff != '1) begin
                        tindex_in = tindex_ff + TIB'(1);
                     end
                     if (reported_ff) begin
                        if (req_data.last) begin
                           match_in    = '0;
                           tindex_in   = '0;
                           reported_in = 1'b0;
                        end
                     end else if (count_ff != '0) begin
                        idx_in  = text_start[IDX_W-1:0];
                        rd_en   = 1'b1;
                        rd_addr = text_start[IDX_W-1:0];
                     end
                  end
                  kmp_pkg::REQ_CLEAR: begin
                     count_in    = '0;
                     match_in    = '0;
                     tindex_in   = '0;
                     reported_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kmp_pkg::ST_WALK: begin
            if (!walk_done) begin
               // mismatch: follow the failure link
               idx_in  = r_fail;
               rd_en   = 1'b1;
               rd_addr = r_fail;
            end else if (finish) begin
               if (is_text_ff) begin
                  if (!empty_ff) begin
                     match_in = step_res;
                  end
                  if (hit) begin
                     reported_in = 1'b1;
                  end
                  if (emit) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.found    = hit;
                     rsp_data_in.position = (hit && !empty_ff) ?
                                            pos_full[kmp_pkg::POS_W-1:0] : '0;
                  end
                  if (last_ff) begin
                     match_in    = '0;
                     tindex_in   = '0;
                     reported_in = 1'b0;
                  end
               end else begin
                  fprev_in = step_res[IDX_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmp_pkg::ST_IDLE;
         count_ff     <= '0;
         match_ff     <= '0;
         tindex_ff    <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         match_ff     <= match_in;
         tindex_ff    <= tindex_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fprev_ff    <= fprev_in;
      idx_ff      <= idx_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      is_text_ff  <= is_text_in;
      empty_ff    <= empty_in;
      here_ff     <= here_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/kmp_ram.sv @@
`timescale 1ns / 1ps
// kmp_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/kmp_stream_matcher_tb.sv @@
`timescale 1ns / 1ps
// kmp_stream_matcher_tb: self-checking bench for the streaming KMP matcher; a directed table
// then random pattern/text sequences, each word predicted and results checked in order.
// Depends on kmp_pkg and kmp_stream_matcher.

module kmp_stream_matcher_tb;

   localparam int          PAT_DEPTH   = 256;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          DRAIN_WAIT  = 300;
   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [31:0] INDEX_TOP   = 32'hFFFF_FFFF;

   // One stimulus row; a pinned row carries its own typed-in result
   typedef struct packed {
      kmp_pkg::kmp_req_type word;
      logic                 pinned;
      logic                 has;
      logic                 found;
      logic [31:0]          pos;
   } stim_row_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   kmp_pkg::kmp_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   kmp_pkg::kmp_rsp_type rsp_data;

   stim_row_type         pin_row   = '0;
   stim_row_type         directed_rows [$];
   kmp_pkg::kmp_rsp_type pending_results [$];

   int send_idle_pct = 31;
   int recv_idle_pct = 58;
   int items_sent    = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   // Shadow matcher state
   logic [7:0]  pat_mem  [PAT_DEPTH];
   logic [7:0]  fail_mem [PAT_DEPTH];
   logic [8:0]  pat_len  = '0;
   logic [8:0]  matched  = '0;
   logic [31:0] text_pos = '0;
   bit          hit_seen = 1'b0;

   // Symbol source for the random sequences
   logic [7:0] alphabet [$];
   bit         any_byte;

   bit                   gives;
   kmp_pkg::kmp_rsp_type predicted, want;

   kmp_stream_matcher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // Move the shadow matcher on by one accepted word
   function automatic void advance_matcher(input kmp_pkg::kmp_req_type w,
                                           output bit has_result,
                                           output kmp_pkg::kmp_rsp_type res);
      logic [8:0]  j;
      logic [8:0]  k;
      logic [31:0] here;
      bit          was_seen;
      bit          hit;
      has_result = 1'b0;
      res        = '0;
      case (w.req_type)
         kmp_pkg::REQ_APPEND: begin
            // a full pattern ignores further bytes and keeps the matcher as it is
            if (pat_len < PAT_DEPTH) begin
               pat_mem[pat_len] = w.symbol;
               if (pat_len == 0) begin
                  j = '0;
               end else begin
                  j = {1'b0, fail_mem[pat_len - 1]};
                  while (j > 0 && pat_mem[j] != w.symbol) j = {1'b0, fail_mem[j - 1]};
                  if (pat_mem[j] == w.symbol) j = j + 1;
               end
               fail_mem[pat_len] = j[7:0];
               pat_len  = pat_len + 1;
               matched  = '0;
               text_pos = '0;
               hit_seen = 1'b0;
            end
         end
         kmp_pkg::REQ_TEXT: begin
            here     = text_pos;
            was_seen = hit_seen;
            hit      = 1'b0;
            if (text_pos != INDEX_TOP) text_pos = text_pos + 1;
            if (!hit_seen) begin
               if (pat_len == 0) begin
                  // empty pattern matches at the very first byte
                  hit          = 1'b1;
                  res.position = '0;
               end else begin
                  k = matched;
                  if (k >= pat_len) k = '0;
                  while (k > 0 && pat_mem[k] != w.symbol) k = {1'b0, fail_mem[k - 1]};
                  if (pat_mem[k] == w.symbol) k = k + 1;
                  matched = k;
                  if (k == pat_len) begin
                     hit          = 1'b1;
                     res.position = here - {23'd0, pat_len} + 32'd1;
                  end
               end
            end
            if (hit) begin
               hit_seen   = 1'b1;
               has_result = 1'b1;
               res.found  = 1'b1;
            end else if (w.last && !was_seen) begin
               has_result = 1'b1;
            end
            if (w.last) begin
               matched  = '0;
               text_pos = '0;
               hit_seen = 1'b0;
            end
         end
         kmp_pkg::REQ_CLEAR: begin
            pat_len  = '0;
            matched  = '0;
            text_pos = '0;
            hit_seen = 1'b0;
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] wanted);
      $display("%0t: mismatch on %s: got %0h, wanted %0h", $time, what, got, wanted);
      error_count++;
   endtask

   // Predict on request handshakes, check on result handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            advance_matcher(req_data, gives, predicted);
            if (pin_row.pinned) begin
               if (pin_row.has) begin
                  want.found    = pin_row.found;
                  want.position = pin_row.pos;
                  pending_results.push_back(want);
               end
            end else if (gives) begin
               pending_results.push_back(predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("unexpected result word", rsp_data.position, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.found !== want.found)
                  flag_mismatch("found", {31'd0, rsp_data.found}, {31'd0, want.found});
               if (rsp_data.position !== want.position)
                  flag_mismatch("position", rsp_data.position, want.position);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Present one word and hold it until taken; returns at a falling edge
   task automatic send_word(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.word;
      pin_row   <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [1:0] kind, input logic [7:0] sym, input logic fin);
      stim_row_type row;
      row               = '0;
      row.word.req_type = kind;
      row.word.symbol   = sym;
      row.word.last     = fin;
      send_word(row);
      items_sent++;
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [7:0] sym, input logic fin,
                          input logic pinned, input logic has, input logic found,
                          input logic [31:0] pos);
      stim_row_type row;
      row.word.req_type = kind;
      row.word.symbol   = sym;
      row.word.last     = fin;
      row.pinned        = pinned;
      row.has           = has;
      row.found         = found;
      row.pos           = pos;
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] pick_symbol();
      if (any_byte) return 8'($urandom_range(255));
      return alphabet[$urandom_range(alphabet.size() - 1)];
   endfunction

   // Pattern load followed by a few texts, some holding a planted copy
   task automatic run_sequence(input bit huge);
      logic [7:0] pat [$];
      logic [7:0] sym;
      int         plen;
      int         ntexts;
      int         pre;
      int         post;
      int         tlen;
      bit         plant;
      bit         open_end;
      alphabet.delete();
      repeat (huge ? 2 : $urandom_range(1, 4)) alphabet.push_back(8'($urandom_range(255)));
      any_byte = !huge && ($urandom_range(7) == 0);
      if (huge || $urandom_range(3) != 0)
         send_plain(kmp_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
      if (huge)
         plen = PAT_DEPTH + $urandom_range(1, 8);
      else if ($urandom_range(9) == 0)
         plen = $urandom_range(7, 24);
      else
         plen = $urandom_range(1, 5);
      repeat (plen) begin
         sym = pick_symbol();
         if (pat.size() < PAT_DEPTH) pat.push_back(sym);
         send_plain(kmp_pkg::REQ_APPEND, sym, 1'($urandom_range(1)));
      end
      ntexts = huge ? 2 : $urandom_range(1, 3);
      repeat (ntexts) begin
         pre      = $urandom_range(0, huge ? 10 : 15);
         post     = $urandom_range(0, huge ? 4 : 12);
         plant    = ($urandom_range(1) == 1);
         open_end = ($urandom_range(11) == 0);
         tlen     = pre + post + (plant ? pat.size() : 0);
         if (tlen == 0) post = 1;
         tlen     = pre + post + (plant ? pat.size() : 0);
         for (int i = 0; i < tlen; i++) begin
            if (plant && i >= pre && i < pre + pat.size())
               sym = pat[i - pre];
            else
               sym = pick_symbol();
            send_plain(kmp_pkg::REQ_TEXT, sym, (i == tlen - 1) && !open_end);
         end
      end
   endtask

   // Unstructured words of every kind, the unused code included
   task automatic run_noise();
      repeat ($urandom_range(1, 6))
         send_plain(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   initial begin
      int target;
      // empty pattern, unused code, then a short pattern with overlap
      add_row(kmp_pkg::REQ_TEXT,   8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(REQ_UNUSED,          8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_APPEND, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_APPEND, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_APPEND, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      // last byte after the match ends the text quietly
      add_row(kmp_pkg::REQ_TEXT,   8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
      // match completing on the last byte
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
      // clear empties the pattern again
      add_row(kmp_pkg::REQ_CLEAR,  8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hAA, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
      add_row(kmp_pkg::REQ_APPEND, 8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_APPEND, 8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      add_row(kmp_pkg::REQ_TEXT,   8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      // Three idling profiles; the middle one also fills the pattern past full
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 58 : 0;
         recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 31 : 0;
         target        = items_sent + 530;
         if (ph == 1) run_sequence(1'b1);
         while (items_sent < target) begin
            if ($urandom_range(9) < 8)
               run_sequence(1'b0);
            else
               run_noise();
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_stream_matcher.sv
sim/kmp_stream_matcher_tb.sv
